// ----- src/kfpv_pkg.sv -----
// Shared types and constants for the position/velocity Kalman filter core.
// Holds fixed-point widths, reset values, the controller state and command types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package kfpv_pkg;

	// Fixed-point format and data widths.
	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;            // signed state and field width
	localparam int VW        = DW - 1;        // width of the non-negative variances
	localparam int PROD_W    = 2 * DW;        // full product width
	localparam int RND_W     = PROD_W - FRAC_BITS;
	localparam int SUM_W     = RND_W + 2;     // room for any sum in the datapath

	// Gain divider: dividend is |p| scaled by 2^FRAC_BITS, divisor is S.
	localparam int S_W        = DW;
	localparam int DIVIDEND_W = DW + FRAC_BITS;
	localparam int DIV_RADIX  = 2;            // quotient bits per cycle
	localparam int DIV_CYC    = (DIVIDEND_W + DIV_RADIX - 1) / DIV_RADIX;
	localparam int DIV_PAD_W  = DIV_CYC * DIV_RADIX;

	localparam int NUM_OPS = 6;               // products in the measurement update
	localparam int CNT_W   = $clog2(DIV_CYC);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_POS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_VEL = 2'd2;

	// Reset values. The initial variance is clipped if it does not fit.
	localparam logic [63:0]   COV_INIT_WIDE = 64'd1000 << FRAC_BITS;
	localparam logic [VW-1:0] COV_INIT = (COV_INIT_WIDE > 64'h7FFF_FFFF) ?
		{VW{1'b1}} : COV_INIT_WIDE[VW-1:0];
	localparam logic [VW-1:0] MEAS_VAR_INIT = VW'(1) << FRAC_BITS;

	// One multiply-and-correct operation of the measurement update.
	typedef enum logic [2:0] {
		OP_P0,
		OP_V0,
		OP_A00,
		OP_A01,
		OP_A10,
		OP_A11
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_GAIN,
		ST_MUL,
		ST_DRAIN,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic    start;      // beat taken: form y and S, load the dividers
		logic    div_step;   // advance both dividers
		logic    gain;       // finish and saturate the two gains
		logic    mul_valid;  // issue one product into the multiplier pipe
		mul_op_t mul_op;
		logic    commit;     // run the prediction and publish the result
	} dp_cmd_t;

	typedef struct packed {
		logic mul_busy;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- src/kfpv_div_lane.sv -----
// A restoring divider lane, DIV_RADIX quotient bits per cycle while step is high.
// Used twice by the datapath to form the two Kalman gains; imports kfpv_pkg.
`default_nettype none

module kfpv_div_lane (
	input  wire logic                           clk,
	input  wire logic                           start,
	input  wire logic                           step,
	input  wire logic [kfpv_pkg::DIV_PAD_W-1:0] dividend,
	input  wire logic [kfpv_pkg::S_W-1:0]       divisor,
	output logic      [kfpv_pkg::DIV_PAD_W-1:0] quotient
);
	import kfpv_pkg::*;

	logic [S_W-1:0]       rem_q;
	logic [DIV_PAD_W-1:0] dq_q;      // dividend bits shift out, quotient bits shift in
	logic [S_W-1:0]       divisor_q;
	logic [S_W-1:0]       rem_n;
	logic [DIV_PAD_W-1:0] dq_n;

	always_comb begin : step_comb
		logic [S_W:0] shifted;
		logic [S_W:0] diff;
		rem_n = rem_q;
		dq_n  = dq_q;
		for (int i = 0; i < DIV_RADIX; i++) begin
			shifted = {rem_n, dq_n[DIV_PAD_W-1]};
			diff    = shifted - {1'b0, divisor_q};
			// The remainder stays below the divisor, so the top bit is the borrow.
			if (!diff[S_W]) begin
				rem_n = diff[S_W-1:0];
			end else begin
				rem_n = shifted[S_W-1:0];
			end
			dq_n = {dq_n[DIV_PAD_W-2:0], ~diff[S_W]};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			dq_q      <= dividend;
			divisor_q <= divisor;
		end else if (step) begin
			rem_q <= rem_n;
			dq_q  <= dq_n;
		end
	end

	assign quotient = dq_q;

endmodule

`default_nettype wire

// ----- src/kfpv_ctrl.sv -----
// Sequencer of the Kalman filter core: handshakes, divider, products, commit.
// Drives the datapath through dp_cmd_t; imports kfpv_pkg.
`default_nettype none

module kfpv_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire kfpv_pkg::dp_status_t status,
	output kfpv_pkg::dp_cmd_t         cmd
);
	import kfpv_pkg::*;

	ctrl_state_t      state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             out_valid_q;

	function automatic mul_op_t op_for(input logic [CNT_W-1:0] idx);
		mul_op_t op;
		case (idx)
			CNT_W'(0): op = OP_P0;
			CNT_W'(1): op = OP_V0;
			CNT_W'(2): op = OP_A00;
			CNT_W'(3): op = OP_A01;
			CNT_W'(4): op = OP_A10;
			CNT_W'(5): op = OP_A11;
			default:   op = OP_P0;
		endcase
		return op;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		cnt_n      = cnt_q;
		cmd        = '0;
		cmd.mul_op = OP_P0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_n     = '0;
					state_n   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
					state_n = ST_GAIN;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				cnt_n    = '0;
				state_n  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_valid = 1'b1;
				cmd.mul_op    = op_for(cnt_q);
				if (cnt_q == CNT_W'(NUM_OPS - 1)) begin
					state_n = ST_DRAIN;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.mul_busy) begin
					state_n = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// The published state is the result, so wait until the last one is gone.
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- src/kfpv_dp.sv -----
// Datapath of the Kalman filter core: configuration, state, gain dividers,
// shared multiplier pipe and saturating adders. Imports kfpv_pkg, uses kfpv_div_lane.
`default_nettype none

module kfpv_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kfpv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kfpv_pkg::DW-1:0]        cfg_data,
	input  wire logic signed [kfpv_pkg::DW-1:0] measured_pos,
	input  wire kfpv_pkg::dp_cmd_t              cmd,
	output kfpv_pkg::dp_status_t                status,
	output logic signed [kfpv_pkg::DW-1:0]      est_pos,
	output logic signed [kfpv_pkg::DW-1:0]      est_vel,
	output logic        [kfpv_pkg::VW-1:0]      var_pos,
	output logic signed [kfpv_pkg::DW-1:0]      cov_pos_vel,
	output logic signed [kfpv_pkg::DW-1:0]      cov_vel_pos,
	output logic        [kfpv_pkg::VW-1:0]      var_vel,
	output logic                                saturated
);
	import kfpv_pkg::*;

	typedef struct packed {
		logic signed [DW-1:0] val;
		logic                 clip;
	} s32_sat_t;

	typedef struct packed {
		logic [VW-1:0] val;
		logic          clip;
	} u31_sat_t;

	localparam logic signed [SUM_W-1:0] S32_MAX_W = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] S32_MIN_W = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [DIV_PAD_W-1:0] Q_POS_MAX = DIV_PAD_W'({1'b0, {(DW-1){1'b1}}});
	localparam logic [DIV_PAD_W-1:0] Q_NEG_MAX = DIV_PAD_W'({1'b1, {(DW-1){1'b0}}});

	function automatic logic signed [SUM_W-1:0] ext_s(input logic [DW-1:0] v);
		return {{(SUM_W-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_u(input logic [VW-1:0] v);
		return {{(SUM_W-VW){1'b0}}, v};
	endfunction

	function automatic s32_sat_t sat_s32(input logic signed [SUM_W-1:0] v);
		s32_sat_t r;
		if (v > S32_MAX_W) begin
			r.val  = S32_MAX_W[DW-1:0];
			r.clip = 1'b1;
		end else if (v < S32_MIN_W) begin
			r.val  = S32_MIN_W[DW-1:0];
			r.clip = 1'b1;
		end else begin
			r.val  = v[DW-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	function automatic u31_sat_t sat_u31(input logic signed [SUM_W-1:0] v);
		u31_sat_t r;
		if (v > S32_MAX_W) begin
			r.val  = {VW{1'b1}};
			r.clip = 1'b1;
		end else if (v[SUM_W-1]) begin
			r.val  = '0;
			r.clip = 1'b1;
		end else begin
			r.val  = v[VW-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	// Configuration.
	logic [VW-1:0]        meas_var_q;
	logic signed [DW-1:0] motion_pos_q;
	logic signed [DW-1:0] motion_vel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_var_q   <= MEAS_VAR_INIT;
			motion_pos_q <= '0;
			motion_vel_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MEAS_VAR:   meas_var_q   <= cfg_data[VW-1:0];
				REG_MOTION_POS: motion_pos_q <= cfg_data;
				REG_MOTION_VEL: motion_vel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state; it is also the published result.
	logic signed [DW-1:0] pos_q, vel_q, cov01_q, cov10_q;
	logic [VW-1:0]        cov00_q, cov11_q;
	logic                 saturated_q;

	// Per-item working registers.
	logic signed [DW-1:0] y_q, k0_q, k1_q;
	logic                 s_zero_q;
	logic                 clip_q;
	logic signed [DW-1:0] p0_q, v0_q, a01_q, a10_q;
	logic [VW-1:0]        a00_q, a11_q;

	// Innovation and innovation variance.
	logic signed [SUM_W-1:0] y_diff;
	s32_sat_t                y_sat;
	logic [S_W-1:0]          s_sum;
	logic [DW-1:0]           cov10_mag;
	logic [DIV_PAD_W-1:0]    dividend0, dividend1;
	logic [DIV_PAD_W-1:0]    quot0, quot1;

	assign y_diff    = ext_s(measured_pos) - ext_s(pos_q);
	assign y_sat     = sat_s32(y_diff);
	assign s_sum     = {1'b0, cov00_q} + {1'b0, meas_var_q};
	assign cov10_mag = cov10_q[DW-1] ? (~cov10_q + 1'b1) : cov10_q;
	assign dividend0 = DIV_PAD_W'({{1'b0, cov00_q}, {FRAC_BITS{1'b0}}});
	assign dividend1 = DIV_PAD_W'({cov10_mag, {FRAC_BITS{1'b0}}});

	kfpv_div_lane u_div_k0 (
		.clk      (clk),
		.start    (cmd.start),
		.step     (cmd.div_step),
		.dividend (dividend0),
		.divisor  (s_sum),
		.quotient (quot0)
	);

	kfpv_div_lane u_div_k1 (
		.clk      (clk),
		.start    (cmd.start),
		.step     (cmd.div_step),
		.dividend (dividend1),
		.divisor  (s_sum),
		.quotient (quot1)
	);

	// Gain saturation. k0 is never negative; k1 takes the sign of p10.
	logic signed [DW-1:0] k0_n, k1_n;
	logic                 k_clip;

	always_comb begin
		k0_n   = quot0[DW-1:0];
		k1_n   = quot1[DW-1:0];
		k_clip = 1'b0;
		if (quot0 > Q_POS_MAX) begin
			k0_n   = Q_POS_MAX[DW-1:0];
			k_clip = 1'b1;
		end
		if (cov10_q[DW-1]) begin
			if (quot1 > Q_NEG_MAX) begin
				k1_n   = Q_NEG_MAX[DW-1:0];
				k_clip = 1'b1;
			end else begin
				k1_n = ~quot1[DW-1:0] + 1'b1;
			end
		end else if (quot1 > Q_POS_MAX) begin
			k1_n   = Q_POS_MAX[DW-1:0];
			k_clip = 1'b1;
		end
		// A zero S only happens with p00 and r both zero; the update is then a no-op.
		if (s_zero_q) begin
			k0_n   = '0;
			k1_n   = '0;
			k_clip = 1'b0;
		end
	end

	// Shared multiplier pipe: operand select and product, rounding, correction.
	logic signed [DW-1:0]     mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	mul_op_t                  op_s1, op_s2;
	logic                     v_s1, v_s2;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [RND_W-1:0]  rnd_s2;

	always_comb begin
		case (cmd.mul_op)
			OP_P0:   begin mul_a = k0_q; mul_b = y_q; end
			OP_V0:   begin mul_a = k1_q; mul_b = y_q; end
			OP_A00:  begin mul_a = k0_q; mul_b = {1'b0, cov00_q}; end
			OP_A01:  begin mul_a = k0_q; mul_b = cov01_q; end
			OP_A10:  begin mul_a = k1_q; mul_b = {1'b0, cov00_q}; end
			OP_A11:  begin mul_a = k1_q; mul_b = cov01_q; end
			default: begin mul_a = '0;   mul_b = '0; end
		endcase
	end

	// Adding half an LSB and dropping the fraction rounds to nearest, ties upward.
	assign rnd_sum = prod_s1 + RND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mul_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		op_s1   <= cmd.mul_op;
		rnd_s2  <= rnd_sum[PROD_W-1:FRAC_BITS];
		op_s2   <= op_s1;
	end

	assign status.mul_busy = v_s1 | v_s2;

	// Correction of state or covariance by the rounded product.
	logic signed [SUM_W-1:0] wb_base, wb_rnd, wb_sum;
	logic                    wb_add;
	s32_sat_t                wb_s32;
	u31_sat_t                wb_u31;

	always_comb begin
		wb_add  = 1'b0;
		case (op_s2)
			OP_P0:   begin wb_base = ext_s(pos_q);   wb_add = 1'b1; end
			OP_V0:   begin wb_base = ext_s(vel_q);   wb_add = 1'b1; end
			OP_A00:  wb_base = ext_u(cov00_q);
			OP_A01:  wb_base = ext_s(cov01_q);
			OP_A10:  wb_base = ext_s(cov10_q);
			OP_A11:  wb_base = ext_u(cov11_q);
			default: wb_base = '0;
		endcase
	end

	assign wb_rnd = {{(SUM_W-RND_W){rnd_s2[RND_W-1]}}, rnd_s2};
	assign wb_sum = wb_add ? (wb_base + wb_rnd) : (wb_base - wb_rnd);
	assign wb_s32 = sat_s32(wb_sum);
	assign wb_u31 = sat_u31(wb_sum);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			y_q      <= y_sat.val;
			s_zero_q <= (s_sum == '0);
		end
		if (cmd.gain) begin
			k0_q <= k0_n;
			k1_q <= k1_n;
		end
		if (v_s2) begin
			case (op_s2)
				OP_P0:   p0_q  <= wb_s32.val;
				OP_V0:   v0_q  <= wb_s32.val;
				OP_A00:  a00_q <= wb_u31.val;
				OP_A01:  a01_q <= wb_s32.val;
				OP_A10:  a10_q <= wb_s32.val;
				OP_A11:  a11_q <= wb_u31.val;
				default: ;
			endcase
		end
	end

	// Clip flag collected over the item.
	logic wb_clip;

	always_comb begin
		case (op_s2)
			OP_A00, OP_A11: wb_clip = wb_u31.clip;
			default:        wb_clip = wb_s32.clip;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (cmd.start) begin
			clip_q <= y_sat.clip;
		end else if (cmd.gain) begin
			clip_q <= clip_q | k_clip;
		end else if (v_s2) begin
			clip_q <= clip_q | wb_clip;
		end
	end

	// Prediction with F = [[1,1],[0,1]] and the external motion.
	logic signed [SUM_W-1:0] pr_pos, pr_vel, pr_c00, pr_c01, pr_c10;
	s32_sat_t                pr_pos_sat, pr_vel_sat, pr_c01_sat, pr_c10_sat;
	u31_sat_t                pr_c00_sat;

	assign pr_pos = ext_s(p0_q) + ext_s(v0_q) + ext_s(motion_pos_q);
	assign pr_vel = ext_s(v0_q) + ext_s(motion_vel_q);
	assign pr_c00 = ext_u(a00_q) + ext_s(a01_q) + ext_s(a10_q) + ext_u(a11_q);
	assign pr_c01 = ext_s(a01_q) + ext_u(a11_q);
	assign pr_c10 = ext_s(a10_q) + ext_u(a11_q);

	assign pr_pos_sat = sat_s32(pr_pos);
	assign pr_vel_sat = sat_s32(pr_vel);
	assign pr_c00_sat = sat_u31(pr_c00);
	assign pr_c01_sat = sat_s32(pr_c01);
	assign pr_c10_sat = sat_s32(pr_c10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			vel_q       <= '0;
			cov00_q     <= COV_INIT;
			cov01_q     <= '0;
			cov10_q     <= '0;
			cov11_q     <= COV_INIT;
			saturated_q <= 1'b0;
		end else if (cmd.commit) begin
			pos_q       <= pr_pos_sat.val;
			vel_q       <= pr_vel_sat.val;
			cov00_q     <= pr_c00_sat.val;
			cov01_q     <= pr_c01_sat.val;
			cov10_q     <= pr_c10_sat.val;
			cov11_q     <= a11_q;
			saturated_q <= clip_q | pr_pos_sat.clip | pr_vel_sat.clip | pr_c00_sat.clip
				| pr_c01_sat.clip | pr_c10_sat.clip;
		end
	end

	assign est_pos     = pos_q;
	assign est_vel     = vel_q;
	assign var_pos     = cov00_q;
	assign cov_pos_vel = cov01_q;
	assign cov_vel_pos = cov10_q;
	assign var_vel     = cov11_q;
	assign saturated   = saturated_q;

endmodule

`default_nettype wire

// ----- src/kalman_filter_pos_vel_core.sv -----
// Top level of the constant-velocity Kalman filter core.
// Instantiates kfpv_ctrl and kfpv_dp; imports kfpv_pkg.
`default_nettype none

// Each input beat is one position measurement in signed Q16.16. The core runs the
// measurement update (innovation, gains K = P column 0 / S, state and covariance
// correction) followed by a one-step prediction with the configured motion terms,
// and returns one result beat holding the predicted state, the covariance and a
// flag that is high when any value of that step was clipped to range. The next
// beat can be taken in the same cycle as the result is published. The steps of
// an item run in this order: the two gain dividers, which run side by side and
// retire two quotient bits per cycle each, saturation of the gains, the issue of
// the six products into the single 32x32 multiplier, the drain of that pipe, and
// the prediction. The result registers are the filter state itself, so a new
// measurement is accepted while the previous result still waits to be taken;
// only the final commit of that new item waits for the output side to be free.
// Configuration writes take effect at once and belong in idle periods; a
// register index beyond the three defined ones is ignored.
module kalman_filter_pos_vel_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kfpv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kfpv_pkg::DW-1:0]        cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [kfpv_pkg::DW-1:0] measured_pos,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [kfpv_pkg::DW-1:0]      est_pos,
	output logic signed [kfpv_pkg::DW-1:0]      est_vel,
	output logic        [kfpv_pkg::VW-1:0]      var_pos,
	output logic signed [kfpv_pkg::DW-1:0]      cov_pos_vel,
	output logic signed [kfpv_pkg::DW-1:0]      cov_vel_pos,
	output logic        [kfpv_pkg::VW-1:0]      var_vel,
	output logic                                saturated
);
	import kfpv_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// The controller owns both handshakes and sequences the datapath.
	kfpv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds configuration, filter state and all arithmetic.
	kfpv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.measured_pos (measured_pos),
		.cmd          (cmd),
		.status       (status),
		.est_pos      (est_pos),
		.est_vel      (est_vel),
		.var_pos      (var_pos),
		.cov_pos_vel  (cov_pos_vel),
		.cov_vel_pos  (cov_vel_pos),
		.var_vel      (var_vel),
		.saturated    (saturated)
	);

endmodule

`default_nettype wire

// ----- verif/kalman_filter_pos_vel_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for kalman_filter_pos_vel_core: directed table plus random tracks.
// Depends on the RTL of the core and on kfpv_pkg for widths and register indexes.

module kalman_filter_pos_vel_core_tb;
	import kfpv_pkg::*;

	// Clock and run length; the settle time at the end is reckoned from LATENCY.
	localparam int CLK_PERIOD  = 10;
	localparam int LATENCY     = 35;          // cycles from an accepted beat to its result
	localparam int END_SETTLE  = 4 * LATENCY;
	localparam int TIMEOUT_NS  = 5_000_000;   // roughly 5x the slowest legal run
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 250;

	// Fixed-point constants of the predictor, kept at 64 bits so no sum can wrap.
	localparam longint Q_ONE  = longint'(1) << FRAC_BITS;
	localparam longint Q_HALF = Q_ONE / 2;
	localparam longint Q_MAX  = 64'sd2147483647;
	localparam longint Q_MIN  = -64'sd2147483648;

	// Index 3 has no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// One result beat: predicted state, covariance and the clip flag.
	typedef struct packed {
		logic [DW-1:0] pos;
		logic [DW-1:0] vel;
		logic [VW-1:0] p00;
		logic [DW-1:0] p01;
		logic [DW-1:0] p10;
		logic [VW-1:0] p11;
		logic          clipped;
	} estimate_t;

	typedef enum logic [0:0] {
		ROW_MEASURE,
		ROW_WRITE
	} row_kind_t;

	// A directed row is either a measurement beat or a register write. Rows with
	// typed set carry an expectation written out by hand; the others are checked
	// against the predictor.
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [DW-1:0]        value;
		logic                 typed;
		estimate_t            want;
	} stim_row_t;

	// Rows below OPEN_ROWS run before the random tracks. The rest run at the very
	// end: they drive the measurement variance down to one LSB and then to zero,
	// which collapses the covariance to zero for good (there is no process noise
	// to grow it back), so nothing that needs a live covariance may follow them.
	localparam int OPEN_ROWS = 22;
	localparam int ROWS      = 34;
	localparam stim_row_t DIRECTED [ROWS] = '{
		// First beat after reset, r = 1.0: the gain is 1000/1001 and P is easy to
		// work out by hand.
		'{ROW_MEASURE, '0, 32'h0000_0000, 1'b1,
			'{32'h0, 32'h0, 31'd65602000, 32'd65536000, 32'd65536000, 31'd65536000, 1'b0}},
		'{ROW_WRITE,   REG_MEAS_VAR,   32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h8000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'hFFFF_FFFF, 1'b0, '0},
		// Largest motion terms push position and velocity into saturation.
		'{ROW_WRITE,   REG_MOTION_POS, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_VEL, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0001_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0001_0000, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_POS, 32'h8000_0000, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_VEL, 32'h8000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h8000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h8000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_POS, 32'h0000_0000, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_VEL, 32'h0000_0000, 1'b0, '0},
		// A write to the undefined index is dropped.
		'{ROW_WRITE,   REG_UNUSED,     32'h5A5A_5A5A, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0000_1000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0000_1000, 1'b0, '0},
		// Bit 31 of the data lies above the 31-bit variance and is dropped.
		'{ROW_WRITE,   REG_MEAS_VAR,   32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0123_4567, 1'b0, '0},
		// Closing rows.
		'{ROW_WRITE,   REG_MOTION_POS, 32'h0000_0000, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_VEL, 32'h0000_0000, 1'b0, '0},
		'{ROW_WRITE,   REG_MEAS_VAR,   32'h0000_0001, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0002_8000, 1'b0, '0},
		// With r = 0 the gain on position is exactly one, P reaches zero within two
		// beats and from then on S is zero, so both gains are forced to zero.
		'{ROW_WRITE,   REG_MEAS_VAR,   32'h0000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h7FFF_FFFF, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h8000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0000_0000, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h0000_0000, 1'b0, '0},
		'{ROW_WRITE,   REG_MOTION_VEL, 32'h0000_0100, 1'b0, '0},
		'{ROW_MEASURE, '0, 32'h1234_5678, 1'b0, '0}
	};

	// Signals driven into the core start at known values.
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [DW-1:0]        cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic signed [DW-1:0] measured_pos = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic signed [DW-1:0] est_pos;
	logic signed [DW-1:0] est_vel;
	logic [VW-1:0]        var_pos;
	logic signed [DW-1:0] cov_pos_vel;
	logic signed [DW-1:0] cov_vel_pos;
	logic [VW-1:0]        var_vel;
	logic                 saturated;

	kalman_filter_pos_vel_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.measured_pos (measured_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.est_pos      (est_pos),
		.est_vel      (est_vel),
		.var_pos      (var_pos),
		.cov_pos_vel  (cov_pos_vel),
		.cov_vel_pos  (cov_vel_pos),
		.var_vel      (var_vel),
		.saturated    (saturated)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The predictor's own copy of the filter state and of the three registers.
	longint f_pos, f_vel, f_p00, f_p01, f_p10, f_p11;
	longint r_var, m_pos, m_vel;
	bit     step_clipped;

	// Expected results in acceptance order, and the failure count.
	estimate_t pending_estimates[$];
	int        failures = 0;
	int        results_seen = 0;

	// Idle modes: when clear, that side runs flat out, giving stretches with no gaps.
	bit idle_in  = 1'b1;
	bit idle_out = 1'b1;

	task automatic log_failure(input string msg);
		$display("%0t ns: result %0d: %s", $time, results_seen, msg);
		failures++;
	endtask

	// Every clip in a step raises the step's saturation flag.
	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v > hi) begin
			step_clipped = 1'b1;
			return hi;
		end
		if (v < lo) begin
			step_clipped = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// Fixed-point product: exact, then shifted down rounding to nearest, ties upward.
	function automatic longint q_mul(input longint a, input longint b);
		return (a * b + Q_HALF) >>> FRAC_BITS;
	endfunction

	// Runs one measurement update and one prediction on the predictor's state and
	// returns the result beat the core should publish for it.
	function automatic estimate_t advance_filter(input logic [DW-1:0] z_bits);
		longint    z, innov, s, k0, k1, p0, v0, a00, a01, a10, a11;
		estimate_t e;
		step_clipped = 1'b0;
		z = longint'($signed(z_bits));
		innov = clamp(z - f_pos, Q_MIN, Q_MAX);
		s = f_p00 + r_var;
		k0 = 0;
		k1 = 0;
		if (s > 0) begin
			// SystemVerilog division truncates toward zero, as the gains require.
			k0 = clamp((f_p00 * Q_ONE) / s, Q_MIN, Q_MAX);
			k1 = clamp((f_p10 * Q_ONE) / s, Q_MIN, Q_MAX);
		end
		p0  = clamp(f_pos + q_mul(k0, innov), Q_MIN, Q_MAX);
		v0  = clamp(f_vel + q_mul(k1, innov), Q_MIN, Q_MAX);
		a00 = clamp(f_p00 - q_mul(k0, f_p00), 0, Q_MAX);
		a01 = clamp(f_p01 - q_mul(k0, f_p01), Q_MIN, Q_MAX);
		a10 = clamp(f_p10 - q_mul(k1, f_p00), Q_MIN, Q_MAX);
		a11 = clamp(f_p11 - q_mul(k1, f_p01), 0, Q_MAX);
		// Prediction with F = [[1,1],[0,1]]: P becomes F P F^T.
		f_pos = clamp(p0 + v0 + m_pos, Q_MIN, Q_MAX);
		f_vel = clamp(v0 + m_vel, Q_MIN, Q_MAX);
		f_p00 = clamp(a00 + a01 + a10 + a11, 0, Q_MAX);
		f_p01 = clamp(a01 + a11, Q_MIN, Q_MAX);
		f_p10 = clamp(a10 + a11, Q_MIN, Q_MAX);
		f_p11 = a11;
		e.pos     = f_pos[DW-1:0];
		e.vel     = f_vel[DW-1:0];
		e.p00     = f_p00[VW-1:0];
		e.p01     = f_p01[DW-1:0];
		e.p10     = f_p10[DW-1:0];
		e.p11     = f_p11[VW-1:0];
		e.clipped = step_clipped;
		return e;
	endfunction

	function automatic logic [DW-1:0] small_motion();
		return DW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	task automatic compare_field(input string name, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		if (got !== want)
			log_failure($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	// Drop valid and hold off until every expected result has been taken.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only while the core is drained. The predictor's copy
	// follows the same decode: the variance keeps 31 bits, index 3 is dropped.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MEAS_VAR: begin
				r_var = longint'(data[VW-1:0]);
			end
			REG_MOTION_POS: begin
				m_pos = longint'($signed(data));
			end
			REG_MOTION_VEL: begin
				m_vel = longint'($signed(data));
			end
			default: begin
			end
		endcase
	endtask

	// Sends one measurement beat. Valid stays high after acceptance so that a
	// beat with no gap follows without a bubble; a drain, or a next call that leaves
	// a gap, lowers it at the following falling edge, before a stray beat is taken.
	task automatic send_meas(input logic [DW-1:0] z, input logic typed,
			input estimate_t want);
		int        gap;
		estimate_t e;
		if ($urandom_range(0, 39) == 0)
			idle_in = !idle_in;
		gap = idle_in ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		measured_pos <= z;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		e = advance_filter(z);
		if (typed)
			e = want;
		pending_estimates = {pending_estimates, e};
	endtask

	task automatic apply_row(input stim_row_t row);
		if (row.kind == ROW_WRITE) begin
			wait_drained();
			write_reg(row.idx, row.value);
		end else begin
			send_meas(row.value, row.typed, row.want);
		end
	endtask

	// Result side: before each result beat the sink may stall for a random number
	// of cycles, then holds stall low until the beat is taken and checked against
	// the oldest pending estimate.
	initial begin : result_sink
		int        hold;
		estimate_t got, want;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				idle_out = !idle_out;
			hold = idle_out ? $urandom_range(0, 19) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			got = '{est_pos, est_vel, var_pos, cov_pos_vel, cov_vel_pos, var_vel, saturated};
			if (pending_estimates.size() == 0) begin
				log_failure("result beat arrived with no measurement pending");
			end else begin
				want = pending_estimates.pop_front();
				compare_field("est_pos", got.pos, want.pos);
				compare_field("est_vel", got.vel, want.vel);
				compare_field("var_pos", DW'(got.p00), DW'(want.p00));
				compare_field("cov_pos_vel", got.p01, want.p01);
				compare_field("cov_vel_pos", got.p10, want.p10);
				compare_field("var_vel", DW'(got.p11), DW'(want.p11));
				compare_field("saturated", DW'(got.clipped), DW'(want.clipped));
			end
			results_seen++;
		end
	end

	// Main sequence: reset, opening rows, random tracks, closing rows, drain.
	initial begin : stimulus
		logic [DW-1:0] r_data, mp_data, mv_data, z;
		longint        trk_pos, trk_vel, amp;
		int            sel;

		// Predictor state after reset: zero state, 1000.0 on the diagonal (clipped
		// if it did not fit), r = 1.0, no motion.
		f_pos = 0;
		f_vel = 0;
		f_p00 = (1000 * Q_ONE > Q_MAX) ? Q_MAX : 1000 * Q_ONE;
		f_p01 = 0;
		f_p10 = 0;
		f_p11 = f_p00;
		r_var = Q_ONE;
		m_pos = 0;
		m_vel = 0;
		trk_pos = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < OPEN_ROWS; i++)
			apply_row(DIRECTED[i]);

		// Random tracks. The variance starts large and shrinks phase by phase, but for
		// phase 3, which draws it at random: a large r keeps the covariance alive, a small
		// one drives it toward zero, after which the covariance path has little left to show.
		for (int phase = 0; phase < PHASES; phase++) begin
			mp_data = small_motion();
			mv_data = small_motion();
			case (phase)
				0: begin
					r_data  = 32'h7FFF_FFFF;
					mp_data = '0;
					mv_data = '0;
				end
				1: r_data = DW'($urandom_range(1 << 29, 32'h7FFF_FFFF));
				2: r_data = DW'($urandom_range(1 << 24, 1 << 29));
				3: begin
					// Full-width random data reaches every register bit.
					r_data  = $urandom;
					mp_data = $urandom;
					mv_data = $urandom;
				end
				default: r_data = DW'($urandom_range(1, 1 << 20));
			endcase
			wait_drained();
			write_reg(REG_MEAS_VAR, r_data);
			write_reg(REG_MOTION_POS, mp_data);
			write_reg(REG_MOTION_VEL, mv_data);
			trk_vel = longint'(int'($urandom_range(0, 1 << 19)) - (1 << 18));

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Now and then the sender waits for the core to drain completely.
				if ($urandom_range(0, 99) == 0)
					wait_drained();
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					z = $urandom;
				end else if (sel == 1) begin
					case ($urandom_range(0, 3))
						0: z = 32'h8000_0000;
						1: z = 32'h7FFF_FFFF;
						2: z = '0;
						default: z = '1;
					endcase
				end else begin
					// Mostly a target moving at constant speed, seen through noise of
					// random size, so the filter actually settles on a track.
					trk_pos += trk_vel;
					if (trk_pos > (1 << 30) || trk_pos < -(1 << 30))
						trk_vel = -trk_vel;
					amp = longint'(1) << $urandom_range(0, 20);
					z = DW'(trk_pos + longint'($urandom_range(0, 2 * amp)) - amp);
				end
				send_meas(z, 1'b0, '0);
			end
		end

		for (int i = OPEN_ROWS; i < ROWS; i++)
			apply_row(DIRECTED[i]);

		// Drain, then watch for stray result beats a while longer.
		wait_drained();
		repeat (END_SETTLE) @(posedge clk);
		if (failures == 0)
			$display("[kalman_filter_pos_vel_core] OK");
		else
			$display("[kalman_filter_pos_vel_core] ERROR");
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("[kalman_filter_pos_vel_core] ERROR");
		$finish;
	end

endmodule
